/* sv/zsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsp_pkg
// shared widths, register indexes, order codes, sequencer codes and types
// ----------------------------------------------------------------------------
package zsp_pkg;

	// payload widths
	localparam int SMP_W   = 24;
	localparam int WLEN_W  = 9;
	localparam int LIMIT_W = 10;
	localparam int THR_W   = 16;
	localparam int ORDER_W = 2;
	localparam int POS_W   = 11;
	localparam int CASH_W  = 48;

	// configuration port
	localparam int CFG_W = 16;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_WINDOW_LEN      = 2'd0;
	localparam logic [IDX_W-1:0] REG_POSITION_LIMIT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_ENTRY_THRESHOLD = 2'd2;

	localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST      = 9'd20;
	localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST  = 10'd1;
	localparam logic [THR_W-1:0]   ENTRY_THRESHOLD_RST = 16'd256;

	// ring depth default
	localparam int MAX_WINDOW_DEF = 256;

	// order codes
	localparam logic [ORDER_W-1:0] ORDER_NONE = 2'd0;
	localparam logic [ORDER_W-1:0] ORDER_SELL = 2'd1;
	localparam logic [ORDER_W-1:0] ORDER_BUY  = 2'd2;

	// sequencer steps
	localparam int STATE_W = 4;
	localparam logic [STATE_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [STATE_W-1:0] ST_EVICT  = 4'd1;
	localparam logic [STATE_W-1:0] ST_SQUARE = 4'd2;
	localparam logic [STATE_W-1:0] ST_SPLIT  = 4'd3;
	localparam logic [STATE_W-1:0] ST_MOMENT = 4'd4;
	localparam logic [STATE_W-1:0] ST_VAR    = 4'd5;
	localparam logic [STATE_W-1:0] ST_SCALE  = 4'd6;
	localparam logic [STATE_W-1:0] ST_SUMUP  = 4'd7;
	localparam logic [STATE_W-1:0] ST_TEST   = 4'd8;
	localparam logic [STATE_W-1:0] ST_TRADE  = 4'd9;
	localparam logic [STATE_W-1:0] ST_MARK   = 4'd10;
	localparam logic [STATE_W-1:0] ST_EMIT   = 4'd11;

	// sequencer control handed to the datapath
	typedef struct packed {
		logic               load;
		logic               clear;
		logic [STATE_W-1:0] step;
	} seq_t;

endpackage

/* sv/zsp_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsp channels
// valid/ready channels for spread samples and trade results
// ----------------------------------------------------------------------------
interface zsp_tick_if;
	logic                             valid;
	logic                             ready;
	logic signed [zsp_pkg::SMP_W-1:0] spread_sample;

	modport source (output valid, output spread_sample, input ready);
	modport sink   (input valid, input spread_sample, output ready);
	modport mon    (input valid, input spread_sample, input ready);
endinterface

interface zsp_trade_if;
	logic                              valid;
	logic                              ready;
	logic [zsp_pkg::ORDER_W-1:0]       order;
	logic                              window_full;
	logic signed [zsp_pkg::POS_W-1:0]  position;
	logic signed [zsp_pkg::CASH_W-1:0] cashflow;
	logic signed [zsp_pkg::CASH_W-1:0] marked_value;

	modport source (output valid, output order, output window_full, output position,
		output cashflow, output marked_value, input ready);
	modport sink   (input valid, input order, input window_full, input position,
		input cashflow, input marked_value, output ready);
	modport mon    (input valid, input order, input window_full, input position,
		input cashflow, input marked_value, input ready);
endinterface

/* sv/zsp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsp_ram
// simple dual port ram, one write and one registered read, read-first
// ----------------------------------------------------------------------------
module zsp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/zsp_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsp_window
// sample ring, running sum and sum of squares, deviation and sum squared
// ----------------------------------------------------------------------------
module zsp_window #(
	parameter int MAX_WINDOW = zsp_pkg::MAX_WINDOW_DEF
) (
	input  logic                                                        clk,
	input  logic                                                        arst_n,
	input  zsp_pkg::seq_t                                               seq,
	input  logic [zsp_pkg::WLEN_W-1:0]                                  window_len,
	input  logic signed [zsp_pkg::SMP_W-1:0]                            sample,
	output logic [$clog2(MAX_WINDOW):0]                                 n,
	output logic signed [zsp_pkg::SMP_W-1:0]                            s,
	output logic                                                        full,
	output logic [2*zsp_pkg::SMP_W-2+$clog2(MAX_WINDOW):0]              sqsum,
	output logic signed [zsp_pkg::SMP_W+$clog2(MAX_WINDOW)+1:0]         d,
	output logic [2*(zsp_pkg::SMP_W+$clog2(MAX_WINDOW))-2:0]            sumsq
);

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int N_W   = AW + 1;
	localparam int SMP_W = zsp_pkg::SMP_W;
	localparam int SUM_W = SMP_W + AW;
	localparam int SQ_W  = 2 * SMP_W - 1 + AW;
	localparam int D_W   = SUM_W + 2;
	localparam int LEN_W = (N_W > zsp_pkg::WLEN_W) ? N_W : zsp_pkg::WLEN_W;

	logic [LEN_W-1:0]              len_ext;
	logic [N_W-1:0]                n_eff;
	logic [N_W-1:0]                fill_q;
	logic [AW-1:0]                 wp_q;
	logic                          evict_now;
	logic [N_W:0]                  wp_ext;
	logic [N_W:0]                  n_ext;
	logic [N_W:0]                  back_direct;
	logic [N_W:0]                  back_wrap;
	logic [AW-1:0]                 raddr;
	logic [SMP_W-1:0]              rdata;
	logic signed [SMP_W-1:0]       old_v;
	logic signed [2*SMP_W-1:0]     old_sq;
	logic signed [2*SMP_W-1:0]     new_sq;
	logic signed [D_W-1:0]         ns_prod;
	logic signed [2*SUM_W-1:0]     sum_sq_full;

	logic signed [SMP_W-1:0]       s_q;
	logic [N_W-1:0]                n_q;
	logic                          evict_q;
	logic                          full_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]               sqsum_q;
	logic [2*SMP_W-2:0]            oldsq_q;
	logic [2*SMP_W-2:0]            ssq_q;
	logic signed [D_W-1:0]         ns_q;
	logic signed [D_W-1:0]         d_q;
	logic [2*SUM_W-2:0]            sumsq_q;

	// window length with zero and oversize folded in
	assign len_ext = LEN_W'(window_len);
	always_comb begin
		if (len_ext == '0) begin
			n_eff = N_W'(1);
		end else if (len_ext > LEN_W'(MAX_WINDOW)) begin
			n_eff = N_W'(MAX_WINDOW);
		end else begin
			n_eff = len_ext[N_W-1:0];
		end
	end

	assign evict_now = (fill_q >= n_eff);

	// oldest sample sits n entries behind the write pointer
	assign wp_ext      = (N_W+1)'(wp_q);
	assign n_ext       = (N_W+1)'(n_eff);
	assign back_direct = wp_ext - n_ext;
	assign back_wrap   = wp_ext + (N_W+1)'(MAX_WINDOW) - n_ext;
	assign raddr       = (wp_ext >= n_ext) ? back_direct[AW-1:0] : back_wrap[AW-1:0];

	zsp_ram #(
		.WIDTH (SMP_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (seq.load),
		.waddr (wp_q),
		.wdata (sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign old_v       = evict_q ? $signed(rdata) : '0;
	assign old_sq      = old_v * old_v;
	assign new_sq      = s_q * s_q;
	assign ns_prod     = $signed({1'b0, n_q}) * s_q;
	assign sum_sq_full = sum_q * sum_q;

	// pointer, fill count and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else if (seq.clear) begin
			wp_q    <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else begin
			if (seq.load) begin
				wp_q   <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
				fill_q <= evict_now ? n_eff : fill_q + N_W'(1);
			end
			if (seq.step == zsp_pkg::ST_EVICT) begin
				sum_q <= sum_q - SUM_W'(old_v) + SUM_W'(s_q);
			end
			if (seq.step == zsp_pkg::ST_SQUARE) begin
				sqsum_q <= sqsum_q - SQ_W'(oldsq_q) + SQ_W'(ssq_q);
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (seq.load) begin
			s_q     <= sample;
			n_q     <= n_eff;
			evict_q <= evict_now;
			full_q  <= evict_now || ((fill_q + N_W'(1)) == n_eff);
		end
		if (seq.step == zsp_pkg::ST_EVICT) begin
			oldsq_q <= old_sq[2*SMP_W-2:0];
			ssq_q   <= new_sq[2*SMP_W-2:0];
			ns_q    <= ns_prod;
		end
		if (seq.step == zsp_pkg::ST_SQUARE) begin
			d_q     <= ns_q - D_W'(sum_q);
			sumsq_q <= sum_sq_full[2*SUM_W-2:0];
		end
	end

	assign n     = n_q;
	assign s     = s_q;
	assign full  = full_q;
	assign sqsum = sqsum_q;
	assign d     = d_q;
	assign sumsq = sumsq_q;

endmodule

/* sv/zsp_decide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsp_decide
// variance, z threshold test, position and cash update, marked value
// ----------------------------------------------------------------------------
module zsp_decide #(
	parameter int MAX_WINDOW = zsp_pkg::MAX_WINDOW_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  zsp_pkg::seq_t                                       seq,
	input  logic [zsp_pkg::LIMIT_W-1:0]                         position_limit,
	input  logic [zsp_pkg::THR_W-1:0]                           entry_threshold,
	input  logic [$clog2(MAX_WINDOW):0]                         n,
	input  logic signed [zsp_pkg::SMP_W-1:0]                    s,
	input  logic                                                full,
	input  logic [2*zsp_pkg::SMP_W-2+$clog2(MAX_WINDOW):0]      sqsum,
	input  logic signed [zsp_pkg::SMP_W+$clog2(MAX_WINDOW)+1:0] d,
	input  logic [2*(zsp_pkg::SMP_W+$clog2(MAX_WINDOW))-2:0]    sumsq,
	output logic [zsp_pkg::ORDER_W-1:0]                         order,
	output logic signed [zsp_pkg::POS_W-1:0]                    position,
	output logic signed [zsp_pkg::CASH_W-1:0]                   cashflow,
	output logic signed [zsp_pkg::CASH_W-1:0]                   marked_value
);

	localparam int AW       = $clog2(MAX_WINDOW);
	localparam int N_W      = AW + 1;
	localparam int SMP_W    = zsp_pkg::SMP_W;
	localparam int SUM_W    = SMP_W + AW;
	localparam int SQ_W     = 2 * SMP_W - 1 + AW;
	localparam int D_W      = SUM_W + 2;
	localparam int HALF     = (SQ_W + 1) / 2;
	localparam int V_W      = N_W + SQ_W;
	localparam int T2_W     = 2 * zsp_pkg::THR_W;
	localparam int PV_SPLIT = 32;
	localparam int Q_SHIFT  = 16;
	localparam int LHS_W    = 2 * SUM_W + Q_SHIFT;
	localparam int RHS_W    = T2_W + V_W;
	localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam int CASH_W   = zsp_pkg::CASH_W;
	localparam int POS_W    = zsp_pkg::POS_W;
	localparam int LIM_W    = zsp_pkg::LIMIT_W + 2;
	localparam int PROD_W   = POS_W + SMP_W;

	function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CASH_W:0] v);
		logic signed [CASH_W-1:0] r;
		if (v[CASH_W] != v[CASH_W-1]) begin
			r = v[CASH_W] ? {1'b1, {(CASH_W-1){1'b0}}} : {1'b0, {(CASH_W-1){1'b1}}};
		end else begin
			r = v[CASH_W-1:0];
		end
		return r;
	endfunction

	logic signed [D_W-1:0]        d_abs;
	logic [V_W-1:0]               sumsq_ext;
	logic signed [LIM_W-1:0]      lim_ext;
	logic signed [LIM_W-1:0]      held_ext;
	logic                         can_sell;
	logic                         can_buy;
	logic signed [CASH_W:0]       cash_ext;
	logic signed [CASH_W:0]       s_ext;
	logic signed [PROD_W-1:0]     prod;

	logic [T2_W-1:0]              t2_q;
	logic [N_W+HALF-1:0]          nlo_q;
	logic [N_W+SQ_W-HALF-1:0]     nhi_q;
	logic [SUM_W-1:0]             ad_q;
	logic [V_W-1:0]               nsq_q;
	logic [2*SUM_W-1:0]           d2_q;
	logic [V_W-1:0]               var_q;
	logic [T2_W+PV_SPLIT-1:0]     pvl_q;
	logic [V_W-1:0]               pvh_q;
	logic [CMP_W-1:0]             rhs_q;
	logic                         beyond_q;
	logic [zsp_pkg::ORDER_W-1:0]  order_q;
	logic signed [POS_W-1:0]      held_q;
	logic signed [CASH_W-1:0]     cash_q;
	logic signed [PROD_W-1:0]     prod_q;

	assign d_abs     = d[D_W-1] ? -d : d;
	assign sumsq_ext = V_W'(sumsq);
	assign prod      = held_q * s;

	// arithmetic chain, each step registers its multiplies and wide adds
	always_ff @(posedge clk) begin
		case (seq.step)
			zsp_pkg::ST_EVICT: begin
				t2_q <= T2_W'(entry_threshold) * T2_W'(entry_threshold);
			end
			zsp_pkg::ST_SPLIT: begin
				nlo_q <= (N_W+HALF)'(n) * (N_W+HALF)'(sqsum[HALF-1:0]);
				nhi_q <= (N_W+SQ_W-HALF)'(n) * (N_W+SQ_W-HALF)'(sqsum[SQ_W-1:HALF]);
				ad_q  <= d_abs[SUM_W-1:0];
			end
			zsp_pkg::ST_MOMENT: begin
				nsq_q <= (V_W'(nhi_q) << HALF) + V_W'(nlo_q);
				d2_q  <= (2*SUM_W)'(ad_q) * (2*SUM_W)'(ad_q);
			end
			zsp_pkg::ST_VAR: begin
				var_q <= (nsq_q > sumsq_ext) ? nsq_q - sumsq_ext : '0;
			end
			zsp_pkg::ST_SCALE: begin
				pvl_q <= (T2_W+PV_SPLIT)'(t2_q) * (T2_W+PV_SPLIT)'(var_q[PV_SPLIT-1:0]);
				pvh_q <= V_W'(t2_q) * V_W'(var_q[V_W-1:PV_SPLIT]);
			end
			zsp_pkg::ST_SUMUP: begin
				rhs_q <= (CMP_W'(pvh_q) << PV_SPLIT) + CMP_W'(pvl_q);
			end
			zsp_pkg::ST_TEST: begin
				beyond_q <= CMP_W'({d2_q, {Q_SHIFT{1'b0}}}) > rhs_q;
			end
			zsp_pkg::ST_MARK: begin
				prod_q <= prod;
			end
			default: begin
			end
		endcase
	end

	// limit checks against the widened position
	assign lim_ext  = $signed({2'b00, position_limit});
	assign held_ext = LIM_W'(held_q);
	assign can_sell = full && !d[D_W-1] && (d != '0) && beyond_q && (held_ext > -lim_ext);
	assign can_buy  = full && d[D_W-1] && beyond_q && (held_ext < lim_ext);
	assign cash_ext = (CASH_W+1)'(cash_q);
	assign s_ext    = (CASH_W+1)'(s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cash_q <= '0;
		end else if (seq.step == zsp_pkg::ST_TRADE) begin
			if (can_sell) begin
				held_q <= held_q - POS_W'(1);
				cash_q <= sat_cash(cash_ext + s_ext);
			end else if (can_buy) begin
				held_q <= held_q + POS_W'(1);
				cash_q <= sat_cash(cash_ext - s_ext);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq.step == zsp_pkg::ST_TRADE) begin
			if (can_sell) begin
				order_q <= zsp_pkg::ORDER_SELL;
			end else if (can_buy) begin
				order_q <= zsp_pkg::ORDER_BUY;
			end else begin
				order_q <= zsp_pkg::ORDER_NONE;
			end
		end
	end

	assign order        = order_q;
	assign position     = held_q;
	assign cashflow     = cash_q;
	assign marked_value = sat_cash(cash_ext + (CASH_W+1)'(prod_q));

endmodule

/* sv/rolling_zscore_pair_trader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_zscore_pair_trader
// rolling z-score mean reversion trader on a pair spread
// ----------------------------------------------------------------------------
//
//  channel  | dir  | handshake        | word
//  ---------+------+------------------+---------------------------------------
//  tick     | in   | valid/ready      | spread_sample, signed Q15.8
//  trade    | out  | valid/ready      | order, window_full, position,
//           |      |                  | cashflow, marked_value
//  cfg      | in   | cfg_we, no ready | cfg_index, cfg_data
//
//  one word at a time: a taken word walks the steps evict, square, split,
//  moment, var, scale, sumup, test, trade, mark and emit, and the result is
//  loaded into the output register on emit; the next word is taken after that
//  the registered multiply and wide add steps advance one per cycle but for emit
//  a result waiting in the output register does not block the next word; the
//  last step holds only while a previous result is still untaken
//  reset clears pointer, fill count, sums, position and cash; the ring needs
//  no clearing pass since an entry is only read after it was written
//
module rolling_zscore_pair_trader #(
	parameter int MAX_WINDOW = zsp_pkg::MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [zsp_pkg::IDX_W-1:0]  cfg_index,
	input  logic [zsp_pkg::CFG_W-1:0]  cfg_data,
	zsp_tick_if.sink                   tick,
	zsp_trade_if.source                trade
);

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int SUM_W = zsp_pkg::SMP_W + AW;
	localparam int SQ_W  = 2 * zsp_pkg::SMP_W - 1 + AW;

	// configuration registers
	logic [zsp_pkg::WLEN_W-1:0]  window_len_q;
	logic [zsp_pkg::LIMIT_W-1:0] position_limit_q;
	logic [zsp_pkg::THR_W-1:0]   entry_threshold_q;

	// sequencer
	logic [zsp_pkg::STATE_W-1:0] state_q;
	logic [zsp_pkg::STATE_W-1:0] state_next;
	zsp_pkg::seq_t               seq;
	logic                        can_emit;

	// window to decision datapath
	logic [AW:0]                 n;
	logic signed [zsp_pkg::SMP_W-1:0] s;
	logic                        full;
	logic [SQ_W-1:0]             sqsum;
	logic signed [SUM_W+1:0]     d;
	logic [2*SUM_W-2:0]          sumsq;

	// decision results
	logic [zsp_pkg::ORDER_W-1:0]       order;
	logic signed [zsp_pkg::POS_W-1:0]  position;
	logic signed [zsp_pkg::CASH_W-1:0] cashflow;
	logic signed [zsp_pkg::CASH_W-1:0] marked_value;

	// output register
	logic                              out_valid_q;
	logic [zsp_pkg::ORDER_W-1:0]       out_order_q;
	logic                              out_full_q;
	logic signed [zsp_pkg::POS_W-1:0]  out_position_q;
	logic signed [zsp_pkg::CASH_W-1:0] out_cash_q;
	logic signed [zsp_pkg::CASH_W-1:0] out_marked_q;

	// config writes must land only while idle, the block does not enforce it; a window length write empties the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q      <= zsp_pkg::WINDOW_LEN_RST;
			position_limit_q  <= zsp_pkg::POSITION_LIMIT_RST;
			entry_threshold_q <= zsp_pkg::ENTRY_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				zsp_pkg::REG_WINDOW_LEN: begin
					window_len_q <= cfg_data[zsp_pkg::WLEN_W-1:0];
				end
				zsp_pkg::REG_POSITION_LIMIT: begin
					position_limit_q <= cfg_data[zsp_pkg::LIMIT_W-1:0];
				end
				zsp_pkg::REG_ENTRY_THRESHOLD: begin
					entry_threshold_q <= cfg_data[zsp_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// a word is taken only between items
	assign tick.ready = (state_q == zsp_pkg::ST_IDLE);
	assign can_emit   = !out_valid_q || trade.ready;

	assign seq.load  = tick.valid && (state_q == zsp_pkg::ST_IDLE);
	assign seq.clear = cfg_we && (cfg_index == zsp_pkg::REG_WINDOW_LEN);
	assign seq.step  = state_q;

	// fixed walk through the datapath steps
	always_comb begin
		case (state_q)
			zsp_pkg::ST_IDLE:   state_next = seq.load ? zsp_pkg::ST_EVICT : zsp_pkg::ST_IDLE;
			zsp_pkg::ST_EVICT:  state_next = zsp_pkg::ST_SQUARE;
			zsp_pkg::ST_SQUARE: state_next = zsp_pkg::ST_SPLIT;
			zsp_pkg::ST_SPLIT:  state_next = zsp_pkg::ST_MOMENT;
			zsp_pkg::ST_MOMENT: state_next = zsp_pkg::ST_VAR;
			zsp_pkg::ST_VAR:    state_next = zsp_pkg::ST_SCALE;
			zsp_pkg::ST_SCALE:  state_next = zsp_pkg::ST_SUMUP;
			zsp_pkg::ST_SUMUP:  state_next = zsp_pkg::ST_TEST;
			zsp_pkg::ST_TEST:   state_next = zsp_pkg::ST_TRADE;
			zsp_pkg::ST_TRADE:  state_next = zsp_pkg::ST_MARK;
			zsp_pkg::ST_MARK:   state_next = zsp_pkg::ST_EMIT;
			zsp_pkg::ST_EMIT:   state_next = can_emit ? zsp_pkg::ST_IDLE : zsp_pkg::ST_EMIT;
			default:            state_next = zsp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	zsp_window #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.seq        (seq),
		.window_len (window_len_q),
		.sample     (tick.spread_sample),
		.n          (n),
		.s          (s),
		.full       (full),
		.sqsum      (sqsum),
		.d          (d),
		.sumsq      (sumsq)
	);

	zsp_decide #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_decide (
		.clk             (clk),
		.arst_n          (arst_n),
		.seq             (seq),
		.position_limit  (position_limit_q),
		.entry_threshold (entry_threshold_q),
		.n               (n),
		.s               (s),
		.full            (full),
		.sqsum           (sqsum),
		.d               (d),
		.sumsq           (sumsq),
		.order           (order),
		.position        (position),
		.cashflow        (cashflow),
		.marked_value    (marked_value)
	);

	// output register, loaded on the last step once the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == zsp_pkg::ST_EMIT) && can_emit) begin
			out_valid_q <= 1'b1;
		end else if (trade.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == zsp_pkg::ST_EMIT) && can_emit) begin
			out_order_q    <= order;
			out_full_q     <= full;
			out_position_q <= position;
			out_cash_q     <= cashflow;
			out_marked_q   <= marked_value;
		end
	end

	assign trade.valid        = out_valid_q;
	assign trade.order        = out_order_q;
	assign trade.window_full  = out_full_q;
	assign trade.position     = out_position_q;
	assign trade.cashflow     = out_cash_q;
	assign trade.marked_value = out_marked_q;

endmodule

/* sv/zsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsp_checker
// port-level checks on the trader, attached to the top level by bind
// ----------------------------------------------------------------------------
module zsp_checker (
	input logic         clk,
	input logic         arst_n,
	zsp_tick_if.sink    tick,
	zsp_trade_if.source trade
);

	// a stalled result keeps its word
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		trade.valid && !trade.ready |=> trade.valid && $stable(trade.order)
			&& $stable(trade.position) && $stable(trade.cashflow)
			&& $stable(trade.marked_value))
		else $error("result word changed while stalled");

	// no trade before the window is full
	a_order_full: assert property (@(posedge clk) disable iff (!arst_n)
		trade.valid && (trade.order != zsp_pkg::ORDER_NONE) |-> trade.window_full)
		else $error("order issued with window not full");

	// position never passes the widest limit
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		trade.valid |-> (trade.position != -11'sd1024))
		else $error("position out of range");

	// one item in flight: busy right after a word is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> !tick.ready)
		else $error("second word taken while an item is in flight");

endmodule

bind rolling_zscore_pair_trader zsp_checker u_zsp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.tick   (tick),
	.trade  (trade)
);
